/* rtl/core/cgst_pkg.sv */
package cgst_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned FACE_W = 3;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned RGB_W  = 24;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;

  localparam logic [SIZE_W-1:0] CUBE_SIZE_RST   = 13'd256;
  localparam logic [RGB_W-1:0]  HORIZON_RGB_RST = 24'hB2CCE5;
  localparam logic [RGB_W-1:0]  ZENITH_RGB_RST  = 24'h3366CC;
  localparam logic [RGB_W-1:0]  NADIR_RGB_RST   = 24'h4C3F33;

  localparam logic [CHAN_W-1:0] ALPHA_VALUE = 8'hFF;

  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;

  typedef enum logic [1:0] {
    REG_CUBE_SIZE = 2'd0,
    REG_HORIZON   = 2'd1,
    REG_ZENITH    = 2'd2,
    REG_NADIR     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [SIZE_W-1:0] cube_size;
    logic [RGB_W-1:0]  horizon_rgb;
    logic [RGB_W-1:0]  zenith_rgb;
    logic [RGB_W-1:0]  nadir_rgb;
  } cfg_t;

endpackage

/* rtl/core/cgst_cfg_regs.sv */
module cgst_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cgst_pkg::ADDR_W-1:0]   paddr,
  input  logic [cgst_pkg::DATA_W-1:0]   pwdata,
  output logic [cgst_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output cgst_pkg::cfg_t                cfg_o
);

  cgst_pkg::cfg_t     cfg_q;
  cgst_pkg::reg_idx_e idx;

  assign idx    = cgst_pkg::reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cube_size   <= cgst_pkg::CUBE_SIZE_RST;
      cfg_q.horizon_rgb <= cgst_pkg::HORIZON_RGB_RST;
      cfg_q.zenith_rgb  <= cgst_pkg::ZENITH_RGB_RST;
      cfg_q.nadir_rgb   <= cgst_pkg::NADIR_RGB_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        cgst_pkg::REG_CUBE_SIZE: cfg_q.cube_size   <= pwdata[cgst_pkg::SIZE_W-1:0];
        cgst_pkg::REG_HORIZON:   cfg_q.horizon_rgb <= pwdata[cgst_pkg::RGB_W-1:0];
        cgst_pkg::REG_ZENITH:    cfg_q.zenith_rgb  <= pwdata[cgst_pkg::RGB_W-1:0];
        cgst_pkg::REG_NADIR:     cfg_q.nadir_rgb   <= pwdata[cgst_pkg::RGB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      cgst_pkg::REG_CUBE_SIZE: prdata = cgst_pkg::DATA_W'(cfg_q.cube_size);
      cgst_pkg::REG_HORIZON:   prdata = cgst_pkg::DATA_W'(cfg_q.horizon_rgb);
      cgst_pkg::REG_ZENITH:    prdata = cgst_pkg::DATA_W'(cfg_q.zenith_rgb);
      cgst_pkg::REG_NADIR:     prdata = cgst_pkg::DATA_W'(cfg_q.nadir_rgb);
      default:                 prdata = '0;
    endcase
  end

endmodule

/* rtl/core/cgst_coord_div.sv */
module cgst_coord_div #(
  parameter int unsigned COORD_BITS = cgst_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = cgst_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [cgst_pkg::FACE_W-1:0]     face_i,
  input  logic [COORD_BITS-1:0]           column_i,
  input  logic [COORD_BITS-1:0]           row_i,
  input  logic [cgst_pkg::SIZE_W-1:0]     size_i,
  output logic                            valid_o,
  output logic [cgst_pkg::FACE_W-1:0]     face_o,
  output logic [1:0][FRAC_BITS+1:0]      quo_o,
  output logic [1:0]                      sat_o
);

  localparam int unsigned AW = COORD_BITS + 1;
  localparam int unsigned SW = cgst_pkg::SIZE_W;
  localparam int unsigned RW = (AW > SW + 2) ? AW : SW + 2;
  localparam int unsigned QW = FRAC_BITS + 2;
  localparam int unsigned NS = QW;
  localparam int unsigned FW = cgst_pkg::FACE_W;

  logic [SW-1:0]      size_eff;
  logic [RW-1:0]      div1;
  logic [RW-1:0]      div2;
  logic [RW-1:0]      div3;
  logic [1:0][AW-1:0] a_d;

  assign size_eff = (size_i == '0) ? SW'(1) : size_i;
  assign div1     = RW'(size_eff);
  assign div2     = div1 << 1;
  assign div3     = div2 + div1;
  assign a_d[0]   = {column_i, 1'b1};
  assign a_d[1]   = {row_i, 1'b1};

  // operand stage
  logic               v0_q;
  logic [FW-1:0]      face0_q;
  logic [1:0]         sat0_q;
  logic [1:0][RW-1:0] rem0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      face0_q <= face_i;
      for (int l = 0; l < 2; l++) begin
        rem0_q[l] <= RW'(a_d[l]);
        sat0_q[l] <= (RW'(a_d[l]) >= div3);
      end
    end
  end

  // restoring division, one quotient bit per stage
  logic               vs_q    [NS];
  logic [FW-1:0]      face_s_q[NS];
  logic [1:0]         sat_s_q [NS];
  logic [1:0][RW-1:0] rem_s_q [NS-1];
  logic [1:0][QW-1:0] quo_s_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic               v_in;
    logic [FW-1:0]      face_in;
    logic [1:0]         sat_in;
    logic [1:0][RW-1:0] rem_in;
    logic [1:0][QW-1:0] quo_in;
    logic [1:0][RW-1:0] trial;
    logic [1:0][RW-1:0] rem_d;
    logic [1:0][QW-1:0] quo_d;
    logic [RW-1:0]      div;

    if (k == 0) begin : g_first
      assign v_in    = v0_q;
      assign face_in = face0_q;
      assign sat_in  = sat0_q;
      assign rem_in  = rem0_q;
      assign quo_in  = '0;
    end else begin : g_next
      assign v_in    = vs_q[k-1];
      assign face_in = face_s_q[k-1];
      assign sat_in  = sat_s_q[k-1];
      assign rem_in  = rem_s_q[k-1];
      assign quo_in  = quo_s_q[k-1];
    end

    assign div = (k == 0) ? div2 : div1;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = (k < 2) ? rem_in[l] : (rem_in[l] << 1);
        if (trial[l] >= div) begin
          rem_d[l] = trial[l] - div;
          quo_d[l] = {quo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[l];
          quo_d[l] = {quo_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k] <= 1'b0;
      end else if (en_i) begin
        vs_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        face_s_q[k] <= face_in;
        sat_s_q[k]  <= sat_in;
        quo_s_q[k]  <= quo_d;
      end
    end

    if (k < NS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_s_q[k] <= rem_d;
        end
      end
    end
  end

  assign valid_o = vs_q[NS-1];
  assign face_o  = face_s_q[NS-1];
  assign quo_o   = quo_s_q[NS-1];
  assign sat_o   = sat_s_q[NS-1];

endmodule

/* rtl/core/cgst_weight.sv */
module cgst_weight #(
  parameter int unsigned FRAC_BITS = cgst_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [cgst_pkg::FACE_W-1:0]   face_i,
  input  logic [1:0][FRAC_BITS+1:0]    quo_i,
  input  logic [1:0]                    sat_i,
  output logic                          valid_o,
  output logic                          up_o,
  output logic [FRAC_BITS:0]            t_o
);

  localparam int unsigned QW  = FRAC_BITS + 2;
  localparam int unsigned MW  = FRAC_BITS + 1;
  localparam int unsigned SQW = 2 * MW;
  localparam int unsigned DW  = 2 * FRAC_BITS + 4;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned NT  = FRAC_BITS + 1;
  localparam int unsigned TW  = FRAC_BITS + 1;

  localparam logic [QW-1:0] ONE    = QW'(1) << FRAC_BITS;
  localparam logic [DW-1:0] ONE_SQ = DW'(1) << (2 * FRAC_BITS);

  // magnitude stage
  logic [1:0][MW-1:0] mag_d;
  logic               up_d;
  logic               pole_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (sat_i[l]) begin
        mag_d[l] = {MW{1'b1}};
      end else if (quo_i[l] >= ONE) begin
        mag_d[l] = MW'(quo_i[l] - ONE);
      end else begin
        mag_d[l] = MW'(ONE - quo_i[l]);
      end
    end
    pole_d = (face_i == cgst_pkg::FACE_POS_Y) || (face_i == cgst_pkg::FACE_NEG_Y);
    if (face_i == cgst_pkg::FACE_POS_Y) begin
      up_d = 1'b1;
    end else if (face_i == cgst_pkg::FACE_NEG_Y) begin
      up_d = 1'b0;
    end else begin
      up_d = !sat_i[1] && (quo_i[1] <= ONE);
    end
  end

  logic               v1_q, up1_q, pole1_q;
  logic [1:0][MW-1:0] mag1_q;
  logic               v2_q, up2_q, pole2_q;
  logic [1:0][SQW-1:0] sq2_q;
  logic               v3_q, up3_q;
  logic [DW-1:0]      den3_q;
  logic [RW-1:0]      rem3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag_d;
      up1_q   <= up_d;
      pole1_q <= pole_d;
      for (int l = 0; l < 2; l++) begin
        sq2_q[l] <= mag1_q[l] * mag1_q[l];
      end
      up2_q   <= up1_q;
      pole2_q <= pole1_q;
      den3_q  <= DW'(sq2_q[0]) + DW'(sq2_q[1]) + ONE_SQ;
      rem3_q  <= pole2_q ? RW'(ONE_SQ) : RW'(sq2_q[1]);
      up3_q   <= up2_q;
    end
  end

  // restoring division of the squared vertical part (one on +Y/-Y) by the squared length
  logic          vr_q  [NT];
  logic          upr_q [NT];
  logic [TW-1:0] tr_q  [NT];
  logic [DW-1:0] denr_q[NT-1];
  logic [RW-1:0] remr_q[NT-1];

  for (genvar k = 0; k < NT; k++) begin : g_step
    logic          v_in;
    logic          up_in;
    logic [TW-1:0] t_in;
    logic [DW-1:0] den_in;
    logic [RW-1:0] rem_in;
    logic [RW-1:0] rem_d;
    logic [TW-1:0] t_d;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in   = v3_q;
      assign up_in  = up3_q;
      assign t_in   = '0;
      assign den_in = den3_q;
      assign rem_in = rem3_q;
    end else begin : g_next
      assign v_in   = vr_q[k-1];
      assign up_in  = upr_q[k-1];
      assign t_in   = tr_q[k-1];
      assign den_in = denr_q[k-1];
      assign rem_in = remr_q[k-1];
    end

    assign ge    = (rem_in >= RW'(den_in));
    assign rem_d = (ge ? (rem_in - RW'(den_in)) : rem_in) << 1;
    assign t_d   = {t_in[TW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vr_q[k] <= 1'b0;
      end else if (en_i) begin
        vr_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        upr_q[k] <= up_in;
        tr_q[k]  <= t_d;
      end
    end

    if (k < NT - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          denr_q[k] <= den_in;
          remr_q[k] <= rem_d;
        end
      end
    end
  end

  assign valid_o = vr_q[NT-1];
  assign up_o    = upr_q[NT-1];
  assign t_o     = tr_q[NT-1];

endmodule

/* rtl/core/cgst_blend.sv */
module cgst_blend #(
  parameter int unsigned FRAC_BITS = cgst_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic                              up_i,
  input  logic [FRAC_BITS:0]                t_i,
  input  cgst_pkg::cfg_t                    cfg_i,
  output logic                              valid_o,
  output logic [2:0][cgst_pkg::CHAN_W-1:0]  chan_o
);

  localparam int unsigned CW = cgst_pkg::CHAN_W;
  localparam int unsigned PW = FRAC_BITS + 2 + CW + 1;

  logic [2:0][CW-1:0] hor;
  logic [2:0][CW-1:0] tgt;
  logic signed [FRAC_BITS+1:0] t_s;
  logic signed [2:0][CW:0]     diff;
  logic [2:0][PW-1:0]          prod_d;

  assign hor = cfg_i.horizon_rgb;
  assign tgt = up_i ? cfg_i.zenith_rgb : cfg_i.nadir_rgb;
  assign t_s = $signed({1'b0, t_i});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c]   = $signed({1'b0, tgt[c]}) - $signed({1'b0, hor[c]});
      prod_d[c] = PW'(t_s * $signed(diff[c]));
    end
  end

  logic               v1_q;
  logic [2:0][PW-1:0] prod1_q;
  logic               v2_q;
  logic [2:0][CW-1:0] chan2_q;
  logic [2:0][PW-1:0] acc;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = prod1_q[c] + (PW'(hor[c]) << FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // the weight stays in [0, 1], so the sum never leaves one byte
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod_d;
      for (int c = 0; c < 3; c++) begin
        chan2_q[c] <= acc[c][FRAC_BITS+CW-1:FRAC_BITS];
      end
    end
  end

  assign valid_o = v2_q;
  assign chan_o  = chan2_q;

endmodule

/* rtl/core/cubemap_gradient_sky_texel.sv */
// Sky color generator for cubemap texels.
// Input stream (s_axis): one word per texel, tuser carries the face
// (+X, -X, +Y, -Y, +Z, -Z as 0..5), tdata the column and the row.
// Output stream (m_axis): one word per input word, in order, holding red,
// green, blue and alpha; alpha is always 255.
// The APB port holds cube_size, horizon_rgb, zenith_rgb and nadir_rgb at
// byte addresses 0, 4, 8 and 12; write them only while no word is in flight.
// Throughput is one texel per clock while the output is not stalled. The
// two restoring dividers produce one quotient bit per stage: FRAC_BITS + 2
// stages for the texel coordinates, FRAC_BITS + 1 for the blend weight;
// the pipeline also holds square, sum, multiply and output stages.
// Reset empties the pipeline and loads the default colors and size 256.
// When the receiver stalls, the output register plus a one-word skid
// register take the last results and the whole pipeline then holds; the
// input is accepted again as soon as the skid register drains.
module cubemap_gradient_sky_texel #(
  parameter int unsigned COORD_BITS = cgst_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = cgst_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // column, row
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // face_index
  input  logic [cgst_pkg::FACE_W-1:0]            s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // red, green, blue, alpha
  output logic [4*cgst_pkg::CHAN_W-1:0]          m_axis_tdata,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [cgst_pkg::ADDR_W-1:0]            paddr,
  input  logic [cgst_pkg::DATA_W-1:0]            pwdata,
  output logic [cgst_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);

  localparam int unsigned OW = 4 * cgst_pkg::CHAN_W;

  cgst_pkg::cfg_t cfg;

  logic                                 en;
  logic                                 cd_valid;
  logic [cgst_pkg::FACE_W-1:0]          cd_face;
  logic [1:0][FRAC_BITS+1:0]            cd_quo;
  logic [1:0]                           cd_sat;
  logic                                 wt_valid;
  logic                                 wt_up;
  logic [FRAC_BITS:0]                   wt_t;
  logic                                 tail_valid;
  logic [2:0][cgst_pkg::CHAN_W-1:0]     tail_chan;
  logic [OW-1:0]                        tail_data;

  logic          out_valid_q;
  logic [OW-1:0] out_data_q;
  logic          skid_valid_q;
  logic [OW-1:0] skid_data_q;

  cgst_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  cgst_coord_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_coord_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .face_i   (s_axis_tuser),
    .column_i (s_axis_tdata[COORD_BITS-1:0]),
    .row_i    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .size_i   (cfg.cube_size),
    .valid_o  (cd_valid),
    .face_o   (cd_face),
    .quo_o    (cd_quo),
    .sat_o    (cd_sat)
  );

  cgst_weight #(
    .FRAC_BITS (FRAC_BITS)
  ) u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cd_valid),
    .face_i  (cd_face),
    .quo_i   (cd_quo),
    .sat_i   (cd_sat),
    .valid_o (wt_valid),
    .up_o    (wt_up),
    .t_o     (wt_t)
  );

  cgst_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (wt_valid),
    .up_i    (wt_up),
    .t_i     (wt_t),
    .cfg_i   (cfg),
    .valid_o (tail_valid),
    .chan_o  (tail_chan)
  );

  assign tail_data = {cgst_pkg::ALPHA_VALUE, tail_chan[0], tail_chan[1], tail_chan[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_axis_tready) begin
        skid_valid_q <= 1'b0;
      end
    end else if (tail_valid) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        out_data_q <= skid_data_q;
      end
    end else if (tail_valid) begin
      if (out_valid_q && !m_axis_tready) begin
        skid_data_q <= tail_data;
      end else begin
        out_data_q <= tail_data;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  localparam int FRAC_W = cgst_pkg::FRAC_BITS_DEF;
  localparam int PIPE_LAT = 2 * FRAC_W + 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DIR_ROWS = 22;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_WORDS = 100;

  localparam logic [cgst_pkg::FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [cgst_pkg::FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [cgst_pkg::FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [cgst_pkg::FACE_W-1:0] FACE_NEG_Z = 3'd5;
  localparam logic [cgst_pkg::FACE_W-1:0] FACE_SPARE_A = 3'd6;
  localparam logic [cgst_pkg::FACE_W-1:0] FACE_SPARE_B = 3'd7;

  typedef struct packed {
    logic [cgst_pkg::CHAN_W-1:0] alpha;
    logic [cgst_pkg::CHAN_W-1:0] blue;
    logic [cgst_pkg::CHAN_W-1:0] green;
    logic [cgst_pkg::CHAN_W-1:0] red;
  } sky_px_t;

  typedef struct packed {
    logic [2:0]                  cfg_sel;
    logic [cgst_pkg::FACE_W-1:0] face;
    logic [11:0]                 col;
    logic [11:0]                 row;
    logic                        known;
    logic [cgst_pkg::RGB_W-1:0]  rgb;
  } texel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [cgst_pkg::FACE_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [cgst_pkg::ADDR_W-1:0] paddr;
  logic [cgst_pkg::DATA_W-1:0] pwdata;
  logic [cgst_pkg::DATA_W-1:0] prdata;
  logic pready;

  cubemap_gradient_sky_texel u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cgst_pkg::cfg_t sky_cfg = '{cgst_pkg::CUBE_SIZE_RST, cgst_pkg::HORIZON_RGB_RST,
                              cgst_pkg::ZENITH_RGB_RST, cgst_pkg::NADIR_RGB_RST};
  sky_px_t sky_expect [$];
  int mismatch_cnt = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit quiet = 1'b0;
  sky_px_t want_px;
  sky_px_t got_px;
  string chan_name [4] = '{"red", "green", "blue", "alpha"};

  cgst_pkg::cfg_t dir_cfg [5] = '{
    '{cgst_pkg::CUBE_SIZE_RST, cgst_pkg::HORIZON_RGB_RST, cgst_pkg::ZENITH_RGB_RST,
      cgst_pkg::NADIR_RGB_RST},
    '{13'd256,  24'h123456, 24'h123456, 24'h123456},
    '{13'd0,    24'hFFFFFF, 24'h000000, 24'hFFFFFF},
    '{13'd4096, 24'h000000, 24'hFFFFFF, 24'h000000},
    '{13'd8191, 24'h00FF00, 24'hFF0000, 24'h0000FF}
  };

  texel_row_t dir_rows [DIR_ROWS] = '{
    '{3'd0, FACE_POS_X,           12'd0,    12'd0,    1'b0, 24'h0},
    '{3'd0, FACE_NEG_X,           12'd255,  12'd255,  1'b0, 24'h0},
    '{3'd0, cgst_pkg::FACE_POS_Y, 12'd128,  12'd128,  1'b0, 24'h0},
    '{3'd0, cgst_pkg::FACE_NEG_Y, 12'd0,    12'd255,  1'b0, 24'h0},
    '{3'd0, FACE_POS_Z,           12'd255,  12'd0,    1'b0, 24'h0},
    '{3'd0, FACE_NEG_Z,           12'd127,  12'd128,  1'b0, 24'h0},
    '{3'd1, FACE_POS_X,           12'd0,    12'd0,    1'b1, 24'h123456},
    '{3'd1, cgst_pkg::FACE_POS_Y, 12'd4095, 12'd4095, 1'b1, 24'h123456},
    '{3'd1, FACE_SPARE_B,         12'd100,  12'd200,  1'b1, 24'h123456},
    '{3'd1, FACE_SPARE_A,         12'd4095, 12'd0,    1'b1, 24'h123456},
    '{3'd2, cgst_pkg::FACE_NEG_Y, 12'd0,    12'd0,    1'b1, 24'hFFFFFF},
    '{3'd2, cgst_pkg::FACE_POS_Y, 12'd0,    12'd0,    1'b0, 24'h0},
    '{3'd2, FACE_POS_X,           12'd4095, 12'd4095, 1'b0, 24'h0},
    '{3'd2, FACE_POS_Z,           12'd0,    12'd4095, 1'b0, 24'h0},
    '{3'd3, cgst_pkg::FACE_NEG_Y, 12'd4095, 12'd0,    1'b1, 24'h000000},
    '{3'd3, FACE_NEG_Z,           12'd4095, 12'd4095, 1'b1, 24'h000000},
    '{3'd3, cgst_pkg::FACE_POS_Y, 12'd2048, 12'd2048, 1'b0, 24'h0},
    '{3'd3, FACE_POS_X,           12'd0,    12'd0,    1'b0, 24'h0},
    '{3'd4, FACE_POS_X,           12'd4095, 12'd4095, 1'b0, 24'h0},
    '{3'd4, FACE_NEG_X,           12'd0,    12'd0,    1'b0, 24'h0},
    '{3'd4, cgst_pkg::FACE_POS_Y, 12'd4095, 12'd0,    1'b0, 24'h0},
    '{3'd4, cgst_pkg::FACE_NEG_Y, 12'd0,    12'd4095, 1'b0, 24'h0}
  };

  // texel center in q2.16, clipped at the top
  function automatic longint coord_q(input logic [11:0] pos, input u64_t size);
    u64_t scaled;
    longint val;
    scaled = ((u64_t'(pos) << 1) + 1) << FRAC_W;
    val = longint'(scaled / size) - (longint'(1) << FRAC_W);
    if (val > (longint'(1) << (FRAC_W + 1)) - 1) val = (longint'(1) << (FRAC_W + 1)) - 1;
    return val;
  endfunction

  function automatic u64_t sq_mag(input longint a);
    u64_t m;
    m = (a < 0) ? u64_t'(-a) : u64_t'(a);
    return m * m;
  endfunction

  function automatic logic [cgst_pkg::CHAN_W-1:0] mix_chan(input logic [7:0] h,
                                                           input logic [7:0] c,
                                                           input u64_t t);
    longint acc;
    longint r;
    acc = (longint'(h) << FRAC_W) + longint'(t) * (longint'(c) - longint'(h));
    if (acc < 0) acc = 0;
    r = acc >>> FRAC_W;
    if (r > 255) r = 255;
    return r[7:0];
  endfunction

  function automatic sky_px_t predict_sky(input logic [cgst_pkg::FACE_W-1:0] face,
                                          input logic [11:0] col, input logic [11:0] row);
    u64_t size, one, den, num, rem, t;
    longint u, v;
    bit up;
    logic [cgst_pkg::RGB_W-1:0] target;
    sky_px_t px;
    size = (sky_cfg.cube_size == '0) ? 1 : u64_t'(sky_cfg.cube_size);
    one = u64_t'(1) << (2 * FRAC_W);
    u = coord_q(col, size);
    v = coord_q(row, size);
    den = sq_mag(u) + sq_mag(v) + one;
    if (face == cgst_pkg::FACE_POS_Y) begin
      num = one;
      up = 1'b1;
    end else if (face == cgst_pkg::FACE_NEG_Y) begin
      num = one;
      up = 1'b0;
    end else begin
      num = sq_mag(v);
      up = (v <= 0);
    end
    // blend weight, one quotient bit per step
    rem = num;
    t = 0;
    for (int i = 0; i <= FRAC_W; i++) begin
      t = t << 1;
      if (rem >= den) begin
        rem = rem - den;
        t = t | 1;
      end
      rem = rem << 1;
    end
    target = up ? sky_cfg.zenith_rgb : sky_cfg.nadir_rgb;
    px.red = mix_chan(sky_cfg.horizon_rgb[23:16], target[23:16], t);
    px.green = mix_chan(sky_cfg.horizon_rgb[15:8], target[15:8], t);
    px.blue = mix_chan(sky_cfg.horizon_rgb[7:0], target[7:0], t);
    px.alpha = cgst_pkg::ALPHA_VALUE;
    return px;
  endfunction

  task automatic apb_write(input cgst_pkg::reg_idx_e idx,
                           input logic [cgst_pkg::DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input cgst_pkg::cfg_t c);
    apb_write(cgst_pkg::REG_CUBE_SIZE, cgst_pkg::DATA_W'(c.cube_size));
    apb_write(cgst_pkg::REG_HORIZON, cgst_pkg::DATA_W'(c.horizon_rgb));
    apb_write(cgst_pkg::REG_ZENITH, cgst_pkg::DATA_W'(c.zenith_rgb));
    apb_write(cgst_pkg::REG_NADIR, cgst_pkg::DATA_W'(c.nadir_rgb));
    sky_cfg = c;
  endtask

  // wait for the pipeline to empty
  task automatic settle_pipe();
    s_axis_tvalid <= 1'b0;
    while (sky_expect.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 8) @(posedge clk_i);
  endtask

  task automatic push_texel(input logic [cgst_pkg::FACE_W-1:0] face, input logic [11:0] col,
                            input logic [11:0] row, input sky_px_t exp_px);
    if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {row, col};
    s_axis_tuser <= face;
    do @(posedge clk_i); while (!s_axis_tready);
    sky_expect.push_back(exp_px);
  endtask

  function automatic logic [11:0] pick_coord(input int size_eff);
    if (size_eff > 4096 || $urandom_range(0, 99) < 20) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(0, size_eff - 1));
  endfunction

  function automatic logic [cgst_pkg::RGB_W-1:0] pick_rgb();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [cgst_pkg::SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 6))
      0: return 13'($urandom_range(1, 8));
      1: return 13'd256;
      2: return 13'd4096;
      3: return 13'd0;
      4: return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  // sink side: random back-pressure and checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_px = m_axis_tdata;
        if (sky_expect.size() == 0) begin
          $display("%0t: word with no expected texel, expected none, actual %h", $time,
                   got_px);
          mismatch_cnt++;
        end else begin
          want_px = sky_expect.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got_px[8*k +: 8] !== want_px[8*k +: 8]) begin
              $display("%0t: %s mismatch, expected %h, actual %h", $time, chan_name[k],
                       want_px[8*k +: 8], got_px[8*k +: 8]);
              mismatch_cnt++;
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left <= $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("cubemap_gradient_sky_texel regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int cur_sel;
    int size_eff;
    cgst_pkg::cfg_t rand_cfg;
    texel_row_t r;
    sky_px_t exp_px;
    logic [cgst_pkg::FACE_W-1:0] face;
    logic [11:0] col, row;

    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    m_axis_tready <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    cur_sel = 0;
    src_idle_pct = 20;
    sink_stall_pct = 20;
    for (int i = 0; i < DIR_ROWS; i++) begin
      r = dir_rows[i];
      if (int'(r.cfg_sel) != cur_sel) begin
        settle_pipe();
        apply_cfg(dir_cfg[r.cfg_sel]);
        cur_sel = r.cfg_sel;
      end
      if (r.known) begin
        exp_px.red = r.rgb[23:16];
        exp_px.green = r.rgb[15:8];
        exp_px.blue = r.rgb[7:0];
        exp_px.alpha = cgst_pkg::ALPHA_VALUE;
      end else begin
        exp_px = predict_sky(r.face, r.col, r.row);
      end
      push_texel(r.face, r.col, r.row, exp_px);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_pipe();
      rand_cfg.cube_size = pick_size();
      rand_cfg.horizon_rgb = pick_rgb();
      rand_cfg.zenith_rgb = pick_rgb();
      rand_cfg.nadir_rgb = pick_rgb();
      apply_cfg(rand_cfg);
      size_eff = (rand_cfg.cube_size == '0) ? 1 : int'(rand_cfg.cube_size);
      case ($urandom_range(0, 3))
        0: src_idle_pct = 0;
        1: src_idle_pct = 10;
        2: src_idle_pct = 30;
        default: src_idle_pct = 60;
      endcase
      case ($urandom_range(0, 3))
        0: sink_stall_pct = 0;
        1: sink_stall_pct = 10;
        2: sink_stall_pct = 30;
        default: sink_stall_pct = 60;
      endcase
      quiet = (p == RAND_PHASES - 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        face = 3'($urandom_range(0, 7));
        col = pick_coord(size_eff);
        row = pick_coord(size_eff);
        push_texel(face, col, row, predict_sky(face, col, row));
      end
    end

    settle_pipe();
    if (mismatch_cnt == 0) begin
      $display("cubemap_gradient_sky_texel regression: pass");
    end else begin
      $display("cubemap_gradient_sky_texel regression: fail");
    end
    $finish;
  end

endmodule
